@@ design/scoped_symbol_stack_defines.svh @@
// ----------------------------------------------------------------------------
// Scoped symbol stack assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_STACK_DEFINES_SVH
`define SCOPED_SYMBOL_STACK_DEFINES_SVH

`ifndef SYNTHESIS
`define SSS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("scoped_symbol_stack: invariant check failed");
`define SSS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scoped_symbol_stack: same-cycle check failed");
`define SSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scoped_symbol_stack: next-cycle check failed");
`else
`define SSS_ASSERT_ALWAYS(lbl, expr)
`define SSS_ASSERT_IMPLY(lbl, ante, cons)
`define SSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol stack package
// Sizes, item kind codes, status codes and shared record types.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_SCOPES  = 64;
  localparam int KEY_BITS    = 16;

  localparam int KIND_W   = 3;
  localparam int KEY_ID_W = 16;
  localparam int ATTR_W   = 32;
  localparam int STATUS_W = 2;

  localparam int KEY_W    = (KEY_BITS < KEY_ID_W) ? KEY_BITS : KEY_ID_W;
  localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
  localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SCOPE_AW = $clog2(MAX_SCOPES);
  localparam int LEVEL_W  = $clog2(MAX_SCOPES + 1);

  localparam logic [KIND_W-1:0] K_INSERT    = KIND_W'(0);
  localparam logic [KIND_W-1:0] K_LOOKUP    = KIND_W'(1);
  localparam logic [KIND_W-1:0] K_ENTER     = KIND_W'(2);
  localparam logic [KIND_W-1:0] K_EXIT      = KIND_W'(3);
  localparam logic [KIND_W-1:0] K_FIND_FUNC = KIND_W'(4);
  localparam logic [KIND_W-1:0] K_CLEAR     = KIND_W'(5);

  localparam logic [STATUS_W-1:0] ST_OK         = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_GLOBAL     = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_SCOPE_FULL = STATUS_W'(3);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ATTR_W-1:0] value;
    logic              func;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [ENTRY_AW-1:0] addr;
    entry_t              data;
  } entry_wr_t;

  typedef struct packed {
    logic                en;
    logic [SCOPE_AW-1:0] addr;
    logic [COUNT_W-1:0]  data;
  } scope_wr_t;

endpackage

@@ design/sss_in_if.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol stack request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface sss_in_if import sss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [KEY_ID_W-1:0] key_id;
  logic                is_function;
  logic [ATTR_W-1:0]   attr_value;

  modport source (output valid, output kind, output key_id, output is_function,
                  output attr_value, input ready);
  modport sink   (input valid, input kind, input key_id, input is_function,
                  input attr_value, output ready);
endinterface

@@ design/sss_out_if.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol stack result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sss_out_if import sss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [ATTR_W-1:0]   value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output found, output value, output status,
                  input ready);
  modport sink   (input valid, input found, input value, input status,
                   output ready);
endinterface

@@ design/sss_entry_store.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol stack entry store
// Entry memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sss_entry_store import sss_pkg::*; (
  input  logic                clk,
  input  entry_wr_t           wr,
  input  logic [ENTRY_AW-1:0] rd_addr,
  output entry_t              rd_data_r
);

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ design/sss_scope_store.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol stack scope store
// Per-scope entry counts of the enclosing scopes, registered read.
// ----------------------------------------------------------------------------
module sss_scope_store import sss_pkg::*; (
  input  logic                clk,
  input  scope_wr_t           wr,
  input  logic [SCOPE_AW-1:0] rd_addr,
  output logic [COUNT_W-1:0]  rd_data_r
);

  logic [COUNT_W-1:0] mem [MAX_SCOPES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ design/scoped_symbol_stack.sv @@
// ----------------------------------------------------------------------------
// Scoped symbol stack
// Stack of symbol entries counted per scope, with newest-first search.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request item (kind, key_id, is_function, attr_value);
//   out_ch returns exactly one result item (found, value, status) per request.
//   in_ch.ready is high only while the sequencer is idle; one request is in
//   work at a time.
//   Insert, enter, clear and unknown kinds go from accept straight to finish.
//   Exit reads the enclosing scope's count in a pop state first, unless at global scope.
//   Lookup and find_function walk the table in a search state, fed by the
//   entry memory read port: the search reads one entry per cycle, newest
//   first, and the shared compare unit checks it the cycle after.
//   A finished result sits in an output register; the next request is taken
//   while it waits. A stalled receiver holds the result and, once a second
//   result is ready, holds the sequencer too.
//   Reset leaves an empty table with only global scope open. No clearing
//   pass is needed: entries above the entry count are never read.
// ----------------------------------------------------------------------------
`include "scoped_symbol_stack_defines.svh"

module scoped_symbol_stack import sss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  cur_r, cur_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [COUNT_W-1:0]  ptr_r, ptr_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                op_func_r, op_func_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic                res_found_r, res_found_nxt;
  logic [ATTR_W-1:0]   res_value_r, res_value_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_found_r, out_found_nxt;
  logic [ATTR_W-1:0]   out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                accept;
  logic                hit;
  logic [COUNT_W-1:0]  ptr_dec;
  logic [LEVEL_W-1:0]  level_m1;
  logic [LEVEL_W-1:0]  level_m2;
  entry_wr_t           ent_wr;
  entry_t              ent_rd;
  scope_wr_t           scp_wr;
  logic [COUNT_W-1:0]  scp_rd;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign accept        = in_ch.valid && in_ch.ready;
  assign ptr_dec       = ptr_r - COUNT_W'(1);
  assign level_m1      = level_r - LEVEL_W'(1);
  assign level_m2      = level_r - LEVEL_W'(2);
  assign hit           = pend_r && (op_func_r ? ent_rd.func : (ent_rd.key == key_r));

  assign out_ch.valid  = out_valid_r;
  assign out_ch.found  = out_found_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    ent_wr.en         = accept && (in_ch.kind == K_INSERT) &&
                        (count_r < COUNT_W'(MAX_ENTRIES));
    ent_wr.addr       = count_r[ENTRY_AW-1:0];
    ent_wr.data.key   = in_ch.key_id[KEY_W-1:0];
    ent_wr.data.value = in_ch.attr_value;
    ent_wr.data.func  = in_ch.is_function;
    scp_wr.en         = accept && (in_ch.kind == K_ENTER) &&
                        (level_r < LEVEL_W'(MAX_SCOPES));
    scp_wr.addr       = level_m1[SCOPE_AW-1:0];
    scp_wr.data       = cur_r;
  end

  sss_entry_store u_entry_store (
    .clk       (clk),
    .wr        (ent_wr),
    .rd_addr   (ptr_dec[ENTRY_AW-1:0]),
    .rd_data_r (ent_rd)
  );

  sss_scope_store u_scope_store (
    .clk       (clk),
    .wr        (scp_wr),
    .rd_addr   (level_m2[SCOPE_AW-1:0]),
    .rd_data_r (scp_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    level_nxt      = level_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    op_func_nxt    = op_func_r;
    key_nxt        = key_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          key_nxt        = in_ch.key_id[KEY_W-1:0];
          op_func_nxt    = (in_ch.kind == K_FIND_FUNC);
          state_nxt      = S_FINISH;
          case (in_ch.kind)
            K_INSERT: begin
              if (count_r >= COUNT_W'(MAX_ENTRIES)) begin
                res_status_nxt = ST_TABLE_FULL;
              end else begin
                count_nxt = count_r + COUNT_W'(1);
                cur_nxt   = cur_r + COUNT_W'(1);
              end
            end
            K_LOOKUP, K_FIND_FUNC: begin
              ptr_nxt   = count_r;
              pend_nxt  = 1'b0;
              state_nxt = S_SEARCH;
            end
            K_ENTER: begin
              if (level_r >= LEVEL_W'(MAX_SCOPES)) begin
                res_status_nxt = ST_SCOPE_FULL;
              end else begin
                cur_nxt   = '0;
                level_nxt = level_r + LEVEL_W'(1);
              end
            end
            K_EXIT: begin
              if (level_r <= LEVEL_W'(1)) begin
                res_status_nxt = ST_GLOBAL;
              end else begin
                count_nxt = (cur_r > count_r) ? '0 : count_r - cur_r;
                cur_nxt   = '0;
                level_nxt = level_m1;
                state_nxt = S_POP;
              end
            end
            K_CLEAR: begin
              count_nxt = '0;
              cur_nxt   = '0;
              level_nxt = LEVEL_W'(1);
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_value_nxt = ent_rd.value;
          pend_nxt      = 1'b0;
          state_nxt     = S_FINISH;
        end else if (ptr_r != '0) begin
          ptr_nxt  = ptr_dec;
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_FINISH;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_POP: begin
        cur_nxt   = scp_rd;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      level_r     <= LEVEL_W'(1);
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      level_r     <= level_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_func_r    <= op_func_nxt;
    key_r        <= key_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  `SSS_ASSERT_ALWAYS(a_level_range, (level_r != '0) && (level_r <= LEVEL_W'(MAX_SCOPES)))
  `SSS_ASSERT_ALWAYS(a_scope_within_table, cur_r <= count_r)
  `SSS_ASSERT_IMPLY(a_search_ptr_bound, state_r == S_SEARCH, ptr_r <= count_r)
  `SSS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE)

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scoped symbol stack testbench
// Drives insert, lookup, scope and search requests over the valid/ready
// request channel, predicts each answer from a behavioral copy of the symbol
// table, and checks every returned result in order. Random idling on both
// channels, one long receiver hold-off, table-full and scope-full fills.
// ----------------------------------------------------------------------------
module tb;
  import sss_pkg::*;

  localparam logic [KIND_W-1:0] K_SPARE6 = KIND_W'(6);
  localparam logic [KIND_W-1:0] K_SPARE7 = KIND_W'(7);

  localparam int TOTAL_ITEMS  = 1250;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic                found;
    logic [ATTR_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } answer_t;

  class symtab_scoreboard;
    logic [KEY_W-1:0]  keys   [MAX_ENTRIES];
    logic [ATTR_W-1:0] attrs  [MAX_ENTRIES];
    bit                funcs  [MAX_ENTRIES];
    int                per_scope [MAX_SCOPES];
    int                depth;
    int                level;
    answer_t           answers_q[$];
    int                failures;
    int                mismatches;

    function new();
      depth      = 0;
      level      = 1;
      per_scope[0] = 0;
      failures   = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_ID_W-1:0] key_id,
                               logic func, logic [ATTR_W-1:0] attr);
      answer_t          a;
      logic [KEY_W-1:0] k;
      int               i;
      a = '0;
      k = key_id[KEY_W-1:0];
      case (kind)
        K_INSERT: begin
          if (depth >= MAX_ENTRIES) begin
            a.status = ST_TABLE_FULL;
          end else begin
            keys[depth]  = k;
            attrs[depth] = attr;
            funcs[depth] = func;
            depth++;
            per_scope[level-1]++;
          end
        end
        K_LOOKUP: begin
          for (i = depth - 1; i >= 0; i--) begin
            if (keys[i] == k) begin
              a.found = 1'b1;
              a.value = attrs[i];
              break;
            end
          end
        end
        K_ENTER: begin
          if (level >= MAX_SCOPES) begin
            a.status = ST_SCOPE_FULL;
          end else begin
            per_scope[level] = 0;
            level++;
          end
        end
        K_EXIT: begin
          if (level <= 1) begin
            a.status = ST_GLOBAL;
          end else begin
            depth = (per_scope[level-1] > depth) ? 0 : depth - per_scope[level-1];
            level--;
          end
        end
        K_FIND_FUNC: begin
          for (i = depth - 1; i >= 0; i--) begin
            if (funcs[i]) begin
              a.found = 1'b1;
              a.value = attrs[i];
              break;
            end
          end
        end
        K_CLEAR: begin
          depth        = 0;
          level        = 1;
          per_scope[0] = 0;
        end
        default: ;
      endcase
      answers_q = {answers_q, a};
    endfunction

    function void check_result(logic found, logic [ATTR_W-1:0] value,
                               logic [STATUS_W-1:0] status);
      answer_t got;
      answer_t want;
      got = {found, value, status};
      if (answers_q.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("unexpected result: found=%0d value=%08h status=%0d",
                   found, value, status);
        mismatches++;
      end else begin
        want = answers_q.pop_front();
        if (got !== want) begin
          failures++;
          if (mismatches < 10)
            $display({"mismatch: expected found=%0d value=%08h status=%0d, ",
                      "got found=%0d value=%08h status=%0d"},
                     want.found, want.value, want.status, found, value, status);
          mismatches++;
        end
      end
    endfunction

    function int outstanding();
      return answers_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sss_in_if  in_ch();
  sss_out_if out_ch();

  scoped_symbol_stack u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  symtab_scoreboard sb = new();

  logic [KEY_ID_W-1:0] key_pool [POOL_SIZE];
  int                  issued      = 0;
  int                  cycles      = 0;
  bit                  tx_calm     = 1'b0;
  bit                  rx_calm     = 1'b0;
  bit                  backlog_req = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("scoped_symbol_stack test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.kind, in_ch.key_id, in_ch.is_function, in_ch.attr_value);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.found, out_ch.value, out_ch.status);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_ch.ready <= 1'b0;
        for (stall = 1; stall < HOLD_CYCLES; stall++) @(negedge clk);
      end else if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (rx_calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  function automatic logic [KEY_ID_W-1:0] pick_key();
    if ($urandom_range(3) == 0) return KEY_ID_W'($urandom);
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // called just after a falling edge; returns just after the falling edge
  // that follows acceptance
  task automatic send_item(logic [KIND_W-1:0] kind, logic [KEY_ID_W-1:0] key,
                           logic func, logic [ATTR_W-1:0] attr);
    while (!tx_calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.key_id      <= key;
    in_ch.is_function <= func;
    in_ch.attr_value  <= attr;
    do @(posedge clk); while (!in_ch.ready);
    if (kind <= K_CLEAR) issued++;
    if (issued == 600) backlog_req = 1'b1;
    tx_calm = (issued >= 850 && issued < 1050);
    rx_calm = tx_calm;
    @(negedge clk);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 34)
      send_item(K_INSERT, pick_key(), 1'($urandom), $urandom);
    else if (r < 58)
      send_item(K_LOOKUP, pick_key(), 1'($urandom), $urandom);
    else if (r < 68)
      send_item(K_ENTER, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    else if (r < 80)
      send_item(K_EXIT, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    else if (r < 91)
      send_item(K_FIND_FUNC, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    else if (r < 94)
      send_item(K_CLEAR, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    else
      send_item(($urandom_range(1) == 0) ? K_SPARE6 : K_SPARE7, KEY_ID_W'($urandom),
                1'($urandom), $urandom);
  endtask

  task automatic fill_scopes();
    while (sb.level < MAX_SCOPES) begin
      send_item(K_ENTER, KEY_ID_W'($urandom), 1'($urandom), $urandom);
      if ($urandom_range(3) == 0)
        send_item(K_INSERT, pick_key(), 1'($urandom), $urandom);
    end
    repeat (2) send_item(K_ENTER, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    send_item(K_LOOKUP, pick_key(), 1'($urandom), $urandom);
    send_item(K_FIND_FUNC, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    while (sb.level > 1) begin
      send_item(K_EXIT, KEY_ID_W'($urandom), 1'($urandom), $urandom);
      if ($urandom_range(3) == 0)
        send_item(K_LOOKUP, pick_key(), 1'($urandom), $urandom);
    end
    send_item(K_EXIT, KEY_ID_W'($urandom), 1'($urandom), $urandom);
  endtask

  task automatic fill_table();
    while (sb.depth < MAX_ENTRIES) begin
      if ($urandom_range(15) == 0)
        send_item(K_LOOKUP, pick_key(), 1'($urandom), $urandom);
      else if ($urandom_range(39) == 0)
        send_item(K_ENTER, KEY_ID_W'($urandom), 1'($urandom), $urandom);
      else
        send_item(K_INSERT, pick_key(), ($urandom_range(7) == 0), $urandom);
    end
    repeat (2) send_item(K_INSERT, pick_key(), 1'($urandom), $urandom);
    send_item(K_LOOKUP, KEY_ID_W'(sb.keys[0]), 1'($urandom), $urandom);
    send_item(K_LOOKUP, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    send_item(K_FIND_FUNC, KEY_ID_W'($urandom), 1'($urandom), $urandom);
    while (sb.level > 1) begin
      send_item(K_EXIT, KEY_ID_W'($urandom), 1'($urandom), $urandom);
      send_item(K_LOOKUP, pick_key(), 1'($urandom), $urandom);
    end
    send_item(K_CLEAR, KEY_ID_W'($urandom), 1'($urandom), $urandom);
  endtask

  initial begin
    int i;
    int phase;
    in_ch.valid       = 1'b0;
    in_ch.kind        = K_INSERT;
    in_ch.key_id      = '0;
    in_ch.is_function = 1'b0;
    in_ch.attr_value  = '0;
    rst_n             = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_ID_W'($urandom);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, global exit, spare kinds, shadowing, clear
    send_item(K_LOOKUP,    16'h0000, 1'b0, 32'h0);
    send_item(K_FIND_FUNC, 16'h0000, 1'b0, 32'h0);
    send_item(K_EXIT,      16'h0000, 1'b0, 32'h0);
    send_item(K_SPARE6,    16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(K_SPARE7,    16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(K_INSERT,    16'h0000, 1'b0, 32'h0000_0000);
    send_item(K_INSERT,    16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(K_INSERT,    16'h5A5A, 1'b0, 32'h1234_5678);
    send_item(K_LOOKUP,    16'hFFFF, 1'b0, 32'h0);
    send_item(K_LOOKUP,    16'h0000, 1'b1, 32'hFFFF_FFFF);
    send_item(K_LOOKUP,    16'h1234, 1'b0, 32'h0);
    send_item(K_FIND_FUNC, 16'h0000, 1'b0, 32'h0);
    send_item(K_ENTER,     16'h0000, 1'b0, 32'h0);
    send_item(K_INSERT,    16'h0000, 1'b1, 32'hA5A5_A5A5);
    send_item(K_LOOKUP,    16'h0000, 1'b0, 32'h0);
    send_item(K_FIND_FUNC, 16'h0000, 1'b0, 32'h0);
    send_item(K_ENTER,     16'h0000, 1'b0, 32'h0);
    send_item(K_EXIT,      16'h0000, 1'b0, 32'h0);
    send_item(K_EXIT,      16'h0000, 1'b0, 32'h0);
    send_item(K_LOOKUP,    16'h0000, 1'b0, 32'h0);
    send_item(K_FIND_FUNC, 16'h0000, 1'b0, 32'h0);
    send_item(K_ENTER,     16'h0000, 1'b0, 32'h0);
    send_item(K_INSERT,    16'h5A5A, 1'b1, 32'h5A5A_5A5A);
    send_item(K_CLEAR,     16'h0000, 1'b0, 32'h0);
    send_item(K_EXIT,      16'h0000, 1'b0, 32'h0);
    send_item(K_LOOKUP,    16'hFFFF, 1'b0, 32'h0);

    phase = 0;
    while (issued < TOTAL_ITEMS) begin
      if (phase == 0 && issued >= 150) begin
        fill_scopes();
        phase = 1;
      end else if (phase == 1 && issued >= 400) begin
        fill_table();
        phase = 2;
      end else if (phase == 2 && issued >= 1000) begin
        fill_scopes();
        phase = 3;
      end else begin
        random_item();
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("scoped_symbol_stack test passed");
    else
      $display("scoped_symbol_stack test failed");
    $finish;
  end

endmodule
